// ===== rtl/core/tcp_tahoe_window_update_unit_assert.svh =====
// Assertion macros shared by the window update unit.
`ifndef TCP_TAHOE_WINDOW_UPDATE_UNIT_ASSERT_SVH
`define TCP_TAHOE_WINDOW_UPDATE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TTWU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttwu: implication check failed");

// Next-cycle implication, checked outside reset.
`define TTWU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttwu: next-cycle check failed");

`endif

// ===== rtl/core/ttwu_pkg.sv =====
// Types, constants and helpers for the TCP Tahoe window update unit.
package ttwu_pkg;

    localparam int WORD_W = 32;
    localparam int MSS_W  = 16;
    localparam int IDX_W  = 2;
    localparam int CNT_W  = $clog2(WORD_W);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [MSS_W-1:0]  mss_t;
    typedef logic [IDX_W-1:0]  reg_idx_t;

    // configuration register indexes
    localparam reg_idx_t REG_MSS  = 2'd0;
    localparam reg_idx_t REG_ITHR = 2'd1;
    localparam reg_idx_t REG_IWIN = 2'd2;

    // event codes
    localparam logic CMD_ACK = 1'b0;
    localparam logic CMD_RTO = 1'b1;

    localparam mss_t  MSS_RESET  = 16'd536;
    localparam word_t ITHR_RESET = 32'd65535;
    localparam word_t IWIN_RESET = 32'd536;

    localparam word_t WORD_MAX = '1;

    function automatic word_t sat_add(input word_t a, input word_t b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? WORD_MAX : s[WORD_W-1:0];
    endfunction

endpackage

// ===== rtl/core/ttwu_serial_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module ttwu_serial_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  ttwu_pkg::word_t dividend,
    input  ttwu_pkg::word_t divisor,
    output logic           done,
    output ttwu_pkg::word_t quotient
);

    localparam logic [ttwu_pkg::CNT_W-1:0] LAST_STEP = ttwu_pkg::CNT_W'(ttwu_pkg::WORD_W - 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [ttwu_pkg::CNT_W-1:0]    count_reg, count_next;
    ttwu_pkg::word_t               rem_reg, rem_next;
    ttwu_pkg::word_t               dq_reg, dq_next;
    ttwu_pkg::word_t               dvs_reg, dvs_next;

    logic [ttwu_pkg::WORD_W:0]     trial;
    logic [ttwu_pkg::WORD_W:0]     diff;
    logic                          ge;

    // dq_reg shifts dividend bits out at the top and quotient bits in at the bottom
    assign trial = {rem_reg, dq_reg[ttwu_pkg::WORD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = ~diff[ttwu_pkg::WORD_W];

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        dq_next    = dq_reg;
        dvs_next   = dvs_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            dq_next    = dividend;
            dvs_next   = divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = ge ? diff[ttwu_pkg::WORD_W-1:0] : trial[ttwu_pkg::WORD_W-1:0];
            dq_next    = {dq_reg[ttwu_pkg::WORD_W-2:0], ge};
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// ===== rtl/core/tcp_tahoe_window_update_unit.sv =====
// TCP Tahoe congestion window and slow-start threshold update unit.
//
// Input stream (s_*): one event per word. s_tdata[0] is the command
// (0 = ack of new data, 1 = retransmission timeout), s_tuser[0] the aborted flag.
// Output stream (m_*): exactly one word per event carrying the window and
// threshold after the event plus the retransmit_one / send_more flags.
// Config port: cfg_we writes cfg_wdata to register cfg_index (0 = mss,
// 1 = initial threshold, 2 = initial window); writing 1 or 2 also reloads the
// live threshold or window. Write only while no event is in flight.
// Timeouts and slow-start acks go from accept through the eval and emit states
// to m_tvalid. Congestion-avoidance acks also pass the mul and div states: the
// mss*mss product is divided by cwnd in a bit-serial divider that retires one
// quotient bit per cycle. One event is processed at a time: a new one is taken
// only once the last has been written to the output register.
// s_tready is high whenever the datapath is idle, even while a finished
// word waits in the output register.
// If the receiver stalls, the next event finishes and holds until the output
// register frees up. Reset loads the register defaults (mss 536, threshold
// 65535, window 536) and empties the output register.
`include "tcp_tahoe_window_update_unit_assert.svh"

module tcp_tahoe_window_update_unit (
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // event input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] command, [7:1] zero
    input  logic [0:0]  s_tuser,    // [0] aborted
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [31:0] window, [63:32] threshold
    output logic [1:0]  m_tuser     // [0] retransmit_one, [1] send_more
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    ttwu_pkg::mss_t    mss_reg, mss_next;
    ttwu_pkg::word_t   cwnd_reg, cwnd_next;
    ttwu_pkg::word_t   ssth_reg, ssth_next;
    ttwu_pkg::word_t   sq_reg, sq_next;
    logic              cmd_reg, cmd_next;
    logic              abort_reg, abort_next;
    logic              rexmit_reg, rexmit_next;
    logic              more_reg, more_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [63:0]       m_tdata_reg, m_tdata_next;
    logic [1:0]        m_tuser_reg, m_tuser_next;

    logic              in_acc;
    logic              out_free;
    logic              div_start;
    logic              div_done;
    ttwu_pkg::word_t   div_quot;
    ttwu_pkg::word_t   div_dvs;
    ttwu_pkg::word_t   half_w;
    ttwu_pkg::word_t   two_mss;
    ttwu_pkg::word_t   incr;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign div_start = (state_reg == ST_MUL);
    // zero window divides by one, giving mss*mss
    assign div_dvs   = (cwnd_reg == '0) ? ttwu_pkg::word_t'(1) : cwnd_reg;
    assign half_w    = cwnd_reg >> 1;
    assign two_mss   = ttwu_pkg::word_t'({mss_reg, 1'b0});
    assign incr      = (div_quot == '0) ? ttwu_pkg::word_t'(1) : div_quot;

    ttwu_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sq_reg),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next    = state_reg;
        mss_next      = mss_reg;
        cwnd_next     = cwnd_reg;
        ssth_next     = ssth_reg;
        sq_next       = sq_reg;
        cmd_next      = cmd_reg;
        abort_next    = abort_reg;
        rexmit_next   = rexmit_reg;
        more_next     = more_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                ttwu_pkg::REG_MSS:
                begin
                    mss_next = cfg_wdata[ttwu_pkg::MSS_W-1:0];
                end
                ttwu_pkg::REG_ITHR:
                begin
                    ssth_next = cfg_wdata;
                end
                ttwu_pkg::REG_IWIN:
                begin
                    cwnd_next = cfg_wdata;
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_next   = s_tdata[0];
                    abort_next = s_tuser[0];
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                rexmit_next = 1'b0;
                more_next   = 1'b0;
                state_next  = ST_EMIT;
                if (cmd_reg == ttwu_pkg::CMD_ACK)
                begin
                    more_next = 1'b1;
                    if (cwnd_reg < ssth_reg)
                    begin
                        cwnd_next = ttwu_pkg::sat_add(cwnd_reg,
                                                      ttwu_pkg::word_t'(mss_reg));
                    end
                    else
                    begin
                        sq_next    = ttwu_pkg::word_t'(mss_reg) * ttwu_pkg::word_t'(mss_reg);
                        state_next = ST_MUL;
                    end
                end
                else if (!abort_reg)
                begin
                    ssth_next   = (half_w > two_mss) ? half_w : two_mss;
                    cwnd_next   = ttwu_pkg::word_t'(mss_reg);
                    rexmit_next = 1'b1;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    cwnd_next  = ttwu_pkg::sat_add(cwnd_reg, incr);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {ssth_reg, cwnd_reg};
                    m_tuser_next  = {more_reg, rexmit_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mss_reg      <= ttwu_pkg::MSS_RESET;
            cwnd_reg     <= ttwu_pkg::IWIN_RESET;
            ssth_reg     <= ttwu_pkg::ITHR_RESET;
            sq_reg       <= '0;
            cmd_reg      <= 1'b0;
            abort_reg    <= 1'b0;
            rexmit_reg   <= 1'b0;
            more_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mss_reg      <= mss_next;
            cwnd_reg     <= cwnd_next;
            ssth_reg     <= ssth_next;
            sq_reg       <= sq_next;
            cmd_reg      <= cmd_next;
            abort_reg    <= abort_next;
            rexmit_reg   <= rexmit_next;
            more_reg     <= more_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `TTWU_ASSERT_IMPLY(a_flags_excl, clk, rst_n, m_tvalid, !(m_tuser[0] && m_tuser[1]))
    `TTWU_ASSERT_IMPLY(a_div_in_div, clk, rst_n, div_done, state_reg == ST_DIV)
    `TTWU_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_acc, state_reg == ST_EVAL)
    `TTWU_ASSERT_NEXT(a_rto_window, clk, rst_n, (state_reg == ST_EMIT) && out_free && rexmit_reg, m_tdata[31:0] == ttwu_pkg::word_t'(mss_reg))

endmodule

// ===== tb/tcp_tahoe_window_update_unit_tb.sv =====
// Testbench for the TCP Tahoe window update unit: event stream in, checked window/threshold out.
`timescale 1ns / 1ps

module tcp_tahoe_window_update_unit_tb;

    localparam int                 CYCLE_LIMIT  = 250000;
    localparam int                 HOLD_CYCLES  = 400;
    localparam int                 PHASES       = 11;
    localparam int                 PHASE_EVENTS = 50;
    // index 3 maps to no register; writes there must be dropped
    localparam ttwu_pkg::reg_idx_t REG_UNUSED   = 2'd3;

    typedef struct {
        ttwu_pkg::word_t window;
        ttwu_pkg::word_t threshold;
        logic            retransmit_one;
        logic            send_more;
    } window_result_t;

    class window_scoreboard;
        ttwu_pkg::word_t cwnd;
        ttwu_pkg::word_t ssthresh;
        ttwu_pkg::mss_t  mss;
        window_result_t  pending[$];
        int              errors;

        function new();
            cwnd     = ttwu_pkg::IWIN_RESET;
            ssthresh = ttwu_pkg::ITHR_RESET;
            mss      = ttwu_pkg::MSS_RESET;
            errors   = 0;
        endfunction

        function void write_reg(ttwu_pkg::reg_idx_t idx, ttwu_pkg::word_t val);
            case (idx)
                ttwu_pkg::REG_MSS:  mss = val[ttwu_pkg::MSS_W-1:0];
                ttwu_pkg::REG_ITHR: ssthresh = val;
                ttwu_pkg::REG_IWIN: cwnd = val;
                default:  ;
            endcase
        endfunction

        function ttwu_pkg::word_t add_clamped(ttwu_pkg::word_t a, ttwu_pkg::word_t b);
            if (a > ttwu_pkg::WORD_MAX - b)
                return ttwu_pkg::WORD_MAX;
            return a + b;
        endfunction

        function void note_event(logic cmd, logic aborted);
            window_result_t  r;
            ttwu_pkg::word_t square;
            ttwu_pkg::word_t step;
            ttwu_pkg::word_t half;
            ttwu_pkg::word_t two_seg;
            r.retransmit_one = 1'b0;
            r.send_more      = 1'b0;
            if (cmd == ttwu_pkg::CMD_ACK) begin
                if (cwnd < ssthresh) begin
                    cwnd = add_clamped(cwnd, ttwu_pkg::word_t'(mss));
                end
                else begin
                    square = ttwu_pkg::word_t'(mss) * ttwu_pkg::word_t'(mss);
                    // zero window divides as if by one
                    step = (cwnd == '0) ? square : square / cwnd;
                    if (step == '0)
                        step = 32'd1;
                    cwnd = add_clamped(cwnd, step);
                end
                r.send_more = 1'b1;
            end
            else if (!aborted) begin
                half     = cwnd >> 1;
                two_seg  = ttwu_pkg::word_t'({mss, 1'b0});
                ssthresh = (half > two_seg) ? half : two_seg;
                cwnd     = ttwu_pkg::word_t'(mss);
                r.retransmit_one = 1'b1;
            end
            r.window    = cwnd;
            r.threshold = ssthresh;
            pending.push_back(r);
        endfunction

        function void check_result(logic [63:0] data, logic [1:0] flags);
            window_result_t e;
            if (pending.size() == 0) begin
                $error("unexpected result word: data %h flags %b", data, flags);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[31:0] !== e.window) begin
                $error("window mismatch: expected %0h, got %0h", e.window, data[31:0]);
                errors++;
            end
            if (data[63:32] !== e.threshold) begin
                $error("threshold mismatch: expected %0h, got %0h", e.threshold, data[63:32]);
                errors++;
            end
            if (flags[0] !== e.retransmit_one) begin
                $error("retransmit_one mismatch: expected %0b, got %0b",
                       e.retransmit_one, flags[0]);
                errors++;
            end
            if (flags[1] !== e.send_more) begin
                $error("send_more mismatch: expected %0b, got %0b", e.send_more, flags[1]);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    ttwu_pkg::reg_idx_t cfg_index;
    logic [31:0]        cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;    // [0] command, [7:1] zero
    logic [0:0]         s_tuser;    // [0] aborted
    logic               m_tvalid;
    logic               m_tready;
    logic [63:0]        m_tdata;    // [31:0] window, [63:32] threshold
    logic [1:0]         m_tuser;    // [0] retransmit_one, [1] send_more

    window_scoreboard sb;
    bit               idle_on;
    int               hold_request;
    int               cycles;

    tcp_tahoe_window_update_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // both handshakes sampled at the edge, before any update lands
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                sb.note_event(s_tdata[0], s_tuser[0]);
        end
    end

    // result side: random stall after each word, plus one long hold on request
    initial
    begin : rx_side
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_tready   = 1'b0;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                stall_left = idle_on ? $urandom_range(0, 6) : 0;
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    // entered and left just after a rising edge
    task automatic send_event(logic cmd, logic aborted);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, cmd};
        s_tuser  <= aborted;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        // the last accepted word is noted at this edge; look from the next one
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_reg(ttwu_pkg::reg_idx_t idx, ttwu_pkg::word_t val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
    endtask

    task automatic end_cfg();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic ttwu_pkg::word_t pick_level();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return $urandom_range(1, 4000);
            2:       return $urandom_range(4000, 200000);
            3:       return $urandom;
            4:       return ttwu_pkg::WORD_MAX - $urandom_range(0, 300000);
            5:       return ttwu_pkg::WORD_MAX;
            default: return ttwu_pkg::ITHR_RESET;
        endcase
    endfunction

    initial
    begin
        ttwu_pkg::word_t mss_val;
        logic            cmd;
        logic            aborted;
        sb           = new();
        cycles       = 0;
        idle_on      = 1'b1;
        hold_request = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = ttwu_pkg::REG_MSS;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults; aborted flag on an ack is don't-care
        send_event(ttwu_pkg::CMD_ACK, 1'b0);
        send_event(ttwu_pkg::CMD_ACK, 1'b1);
        send_event(ttwu_pkg::CMD_RTO, 1'b1);
        send_event(ttwu_pkg::CMD_RTO, 1'b0);
        send_event(ttwu_pkg::CMD_ACK, 1'b0);

        // largest segment, window near max: saturation in avoidance
        wait_until_idle();
        set_reg(ttwu_pkg::REG_MSS, {16'hA5A5, 16'hFFFF});
        set_reg(ttwu_pkg::REG_ITHR, '0);
        set_reg(ttwu_pkg::REG_IWIN, 32'hFFFF_FFFE);
        end_cfg();
        send_event(ttwu_pkg::CMD_ACK, 1'b0);
        send_event(ttwu_pkg::CMD_ACK, 1'b0);
        send_event(ttwu_pkg::CMD_RTO, 1'b0);
        send_event(ttwu_pkg::CMD_ACK, 1'b0);

        // saturation in slow start
        wait_until_idle();
        set_reg(ttwu_pkg::REG_ITHR, ttwu_pkg::WORD_MAX);
        set_reg(ttwu_pkg::REG_IWIN, 32'hFFFF_FF00);
        end_cfg();
        send_event(ttwu_pkg::CMD_ACK, 1'b0);
        send_event(ttwu_pkg::CMD_ACK, 1'b0);

        // zero window in avoidance
        wait_until_idle();
        set_reg(ttwu_pkg::REG_MSS, 32'd1000);
        set_reg(ttwu_pkg::REG_ITHR, '0);
        set_reg(ttwu_pkg::REG_IWIN, '0);
        end_cfg();
        send_event(ttwu_pkg::CMD_ACK, 1'b0);
        send_event(ttwu_pkg::CMD_RTO, 1'b0);

        // zero segment size
        wait_until_idle();
        set_reg(ttwu_pkg::REG_MSS, '0);
        set_reg(ttwu_pkg::REG_IWIN, 32'd100);
        end_cfg();
        send_event(ttwu_pkg::CMD_ACK, 1'b0);
        send_event(ttwu_pkg::CMD_RTO, 1'b0);
        send_event(ttwu_pkg::CMD_ACK, 1'b1);
        send_event(ttwu_pkg::CMD_RTO, 1'b1);
        send_event(ttwu_pkg::CMD_ACK, 1'b0);
        wait_until_idle();
        set_reg(REG_UNUSED, 32'h1234_5678);
        set_reg(ttwu_pkg::REG_ITHR, '0);
        end_cfg();
        send_event(ttwu_pkg::CMD_ACK, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            wait_until_idle();
            idle_on = (p % 4 != 1);
            case ($urandom_range(0, 5))
                0:       mss_val = '0;
                1:       mss_val = $urandom_range(1, 64);
                2:       mss_val = 32'd536;
                3:       mss_val = 32'd1460;
                4:       mss_val = $urandom_range(1, 65535);
                default: mss_val = 32'd65535;
            endcase
            set_reg(ttwu_pkg::REG_MSS, mss_val);
            if ($urandom_range(0, 3) != 0)
                set_reg(ttwu_pkg::REG_ITHR, pick_level());
            if ($urandom_range(0, 3) != 0)
                set_reg(ttwu_pkg::REG_IWIN, pick_level());
            end_cfg();
            if (p == 3) begin
                // sink goes quiet while the source keeps pushing
                idle_on = 1'b0;
                @(negedge clk);
                hold_request = HOLD_CYCLES;
                @(posedge clk);
            end
            for (int k = 0; k < PHASE_EVENTS; k++) begin
                cmd     = ($urandom_range(0, 99) < 82) ? ttwu_pkg::CMD_ACK : ttwu_pkg::CMD_RTO;
                aborted = (cmd == ttwu_pkg::CMD_RTO) ? ($urandom_range(0, 3) == 0)
                                                     : logic'($urandom_range(0, 1));
                send_event(cmd, aborted);
            end
        end

        wait_until_idle();
        repeat (60) @(posedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
